>>> hw/rtl/deadline_min_heap_timer_defines.svh
// assertion macros for the deadline heap timer
`ifndef DEADLINE_MIN_HEAP_TIMER_DEFINES_SVH
`define DEADLINE_MIN_HEAP_TIMER_DEFINES_SVH
`ifndef SYNTHESIS
`define DMHT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dmht check failed");
`define DMHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dmht check failed");
`else
`define DMHT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DMHT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/dmht_pkg.sv
// shared types and constants of the deadline heap timer
package dmht_pkg;
   localparam int DEPTH    = 32;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int KID_W    = IDX_W + 2;
   localparam int MAX_POPS = 32;
   localparam int POP_W    = $clog2(MAX_POPS + 1);
   localparam int TIME_W   = 40;
   localparam int TAG_W    = 16;
   localparam int DELAY_W  = 32;

   localparam logic [1:0] ST_ADDED   = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_EXPIRED = 2'd2;
   localparam logic [1:0] ST_TICK    = 2'd3;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [2:0] {
      RD_NONE, RD_ROOT, RD_PARENT, RD_LAST, RD_KIDS
   } rd_op_type;

   typedef enum logic [1:0] {
      WR_NONE, WR_HOLD, WR_PARENT, WR_CHILD
   } wr_op_type;

   typedef struct packed {
      logic       accept_add;
      logic       accept_tick;
      rd_op_type  rd_op;
      wr_op_type  wr_op;
      logic       load_last;
      logic       pop;
      logic       emit;
      logic [1:0] emit_status;
   } cmd_type;

   typedef struct packed {
      logic             full;
      logic             hole_zero;
      logic             add_less;
      logic             pop_due;
      logic             more;
      logic             has_left;
      logic             sd_move;
      logic             rsp_free;
      logic [CNT_W-1:0] count;
   } sts_type;
endpackage

>>> hw/rtl/deadline_min_heap_timer.sv
// channel  direction  tdata                          tuser        tlast
// req      in         tag[15:0], delay[47:16]        kind         -
// rsp      out        expired_tag[15:0], secs[55:16] status[1:0]  last
//
// one item at a time; the heap sits in a two-read one-write memory
// an add sifts the new entry up the heap, comparing it with one parent per level
// a tick advances the time base, then pops each expired entry and sifts the last entry down
// synchronous active-high reset empties the heap and zeroes the time base
// a held result stalls the controller before its next result
`include "deadline_min_heap_timer_defines.svh"
module deadline_min_heap_timer import dmht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // tag, delay
   input  logic        req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // expired_tag, seconds_to_next
   output logic [1:0]  rsp_tuser,  // status
   output logic        rsp_tlast
);
   cmd_type           cmd;
   sts_type           sts;
   logic [TAG_W-1:0]  rsp_tag;
   logic [TIME_W-1:0] rsp_secs;

   dmht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dmht_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tag    (req_tdata[15:0]),
      .req_delay  (req_tdata[47:16]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_tag    (rsp_tag),
      .rsp_secs   (rsp_secs),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_secs, rsp_tag};

   `DMHT_ASSERT_NEXT(a_full_refused, clock, reset, req_tvalid && req_tready && req_tuser == KIND_ADD && sts.full, rsp_tvalid && rsp_tuser == ST_FULL)
   `DMHT_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, sts.count <= CNT_W'(DEPTH))
   `DMHT_ASSERT_IMPL(a_expired_not_last, clock, reset, rsp_tvalid && rsp_tuser == ST_EXPIRED, !rsp_tlast)
endmodule

>>> hw/rtl/dmht_ctrl.sv
// controller state machine of the deadline heap timer
module dmht_ctrl import dmht_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   input  logic    req_kind,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_ADD_RD   = 9'b000000010,
      S_ADD_CMP  = 9'b000000100,
      S_ADD_DONE = 9'b000001000,
      S_POP_RD   = 9'b000010000,
      S_POP_CHK  = 9'b000100000,
      S_POP_LAST = 9'b001000000,
      S_SD_RD    = 9'b010000000,
      S_SD_CMP   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && sts.rsp_free;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_op       = RD_NONE;
      cmd.wr_op       = WR_NONE;
      cmd.emit_status = ST_ADDED;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && sts.rsp_free) begin
               if (req_kind == KIND_TICK) begin
                  cmd.accept_tick = 1'b1;
                  state_in        = S_POP_RD;
               end else if (sts.full) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_status = ST_FULL;
               end else begin
                  cmd.accept_add = 1'b1;
                  state_in       = S_ADD_RD;
               end
            end
         end
         S_ADD_RD: begin
            if (sts.hole_zero) begin
               cmd.wr_op = WR_HOLD;
               state_in  = S_ADD_DONE;
            end else begin
               cmd.rd_op = RD_PARENT;
               state_in  = S_ADD_CMP;
            end
         end
         S_ADD_CMP: begin
            if (sts.add_less) begin
               cmd.wr_op = WR_PARENT;
               state_in  = S_ADD_RD;
            end else begin
               cmd.wr_op = WR_HOLD;
               state_in  = S_ADD_DONE;
            end
         end
         S_ADD_DONE: begin
            if (sts.rsp_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_ADDED;
               state_in        = S_IDLE;
            end
         end
         S_POP_RD: begin
            cmd.rd_op = RD_ROOT;
            state_in  = S_POP_CHK;
         end
         S_POP_CHK: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               if (sts.pop_due) begin
                  cmd.emit_status = ST_EXPIRED;
                  cmd.pop         = 1'b1;
                  if (sts.more) begin
                     cmd.rd_op = RD_LAST;
                     state_in  = S_POP_LAST;
                  end else begin
                     state_in = S_POP_RD;
                  end
               end else begin
                  cmd.emit_status = ST_TICK;
                  state_in        = S_IDLE;
               end
            end
         end
         S_POP_LAST: begin
            cmd.load_last = 1'b1;
            state_in      = S_SD_RD;
         end
         S_SD_RD: begin
            if (sts.has_left) begin
               cmd.rd_op = RD_KIDS;
               state_in  = S_SD_CMP;
            end else begin
               cmd.wr_op = WR_HOLD;
               state_in  = S_POP_RD;
            end
         end
         S_SD_CMP: begin
            if (sts.sd_move) begin
               cmd.wr_op = WR_CHILD;
               state_in  = S_SD_RD;
            end else begin
               cmd.wr_op = WR_HOLD;
               state_in  = S_POP_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

>>> hw/rtl/dmht_datapath.sv
// heap memory, time base and result register of the deadline heap timer
module dmht_datapath import dmht_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [TAG_W-1:0]    req_tag,
   input  logic [DELAY_W-1:0]  req_delay,
   input  cmd_type             cmd,
   output sts_type             sts,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [1:0]          rsp_status,
   output logic [TAG_W-1:0]    rsp_tag,
   output logic [TIME_W-1:0]   rsp_secs,
   output logic                rsp_last
);
   logic [TIME_W-1:0] heap_dl_ff  [DEPTH];
   logic [TAG_W-1:0]  heap_tag_ff [DEPTH];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [POP_W-1:0]  pops_ff, pops_in;
   logic [IDX_W-1:0]  hole_ff, hole_in;
   logic [TIME_W-1:0] hold_dl_ff, hold_dl_in;
   logic [TAG_W-1:0]  hold_tag_ff, hold_tag_in;
   logic [TIME_W-1:0] rda_dl_ff, rdb_dl_ff;
   logic [TAG_W-1:0]  rda_tag_ff, rdb_tag_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [TAG_W-1:0]  rsp_tag_ff;
   logic [TIME_W-1:0] rsp_secs_ff;
   logic              rsp_last_ff;

   logic [IDX_W-1:0]  parent_idx, last_idx, left_idx, right_idx, pick_idx;
   logic [KID_W-1:0]  left_w, right_w;
   logic              right_ok, pick_right;
   logic [IDX_W-1:0]  rda_addr, rdb_addr, wr_addr;
   logic              rd_en, wr_en;
   logic [TIME_W-1:0] wr_dl;
   logic [TAG_W-1:0]  wr_tag;

   assign parent_idx = (hole_ff - IDX_W'(1)) >> 1;
   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));
   assign left_w     = {1'b0, hole_ff, 1'b1};
   assign right_w    = left_w + KID_W'(1);
   assign left_idx   = left_w[IDX_W-1:0];
   assign right_idx  = right_w[IDX_W-1:0];
   assign right_ok   = right_w < KID_W'(count_ff);
   // ties go right
   assign pick_right = right_ok && !(rda_dl_ff < rdb_dl_ff);
   assign pick_idx   = pick_right ? right_idx : left_idx;

   always_comb begin
      rd_en    = 1'b1;
      rda_addr = '0;
      rdb_addr = '0;
      case (cmd.rd_op)
         RD_ROOT:   rda_addr = '0;
         RD_PARENT: rda_addr = parent_idx;
         RD_LAST:   rda_addr = last_idx;
         RD_KIDS: begin
            rda_addr = left_idx;
            rdb_addr = right_idx;
         end
         default:   rd_en = 1'b0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = hole_ff;
      wr_dl   = hold_dl_ff;
      wr_tag  = hold_tag_ff;
      case (cmd.wr_op)
         WR_HOLD: ;
         WR_PARENT: begin
            wr_dl  = rda_dl_ff;
            wr_tag = rda_tag_ff;
         end
         WR_CHILD: begin
            wr_dl  = pick_right ? rdb_dl_ff : rda_dl_ff;
            wr_tag = pick_right ? rdb_tag_ff : rda_tag_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_dl_ff[wr_addr]  <= wr_dl;
         heap_tag_ff[wr_addr] <= wr_tag;
      end
      if (rd_en) begin
         rda_dl_ff  <= heap_dl_ff[rda_addr];
         rda_tag_ff <= heap_tag_ff[rda_addr];
         rdb_dl_ff  <= heap_dl_ff[rdb_addr];
         rdb_tag_ff <= heap_tag_ff[rdb_addr];
      end
   end

   always_comb begin
      count_in    = count_ff;
      now_in      = now_ff;
      pops_in     = pops_ff;
      hole_in     = hole_ff;
      hold_dl_in  = hold_dl_ff;
      hold_tag_in = hold_tag_ff;
      if (cmd.accept_add) begin
         hold_dl_in  = now_ff + TIME_W'(req_delay);
         hold_tag_in = req_tag;
         hole_in     = IDX_W'(count_ff);
         count_in    = count_ff + CNT_W'(1);
      end
      if (cmd.accept_tick) begin
         now_in  = now_ff + TIME_W'(1);
         pops_in = '0;
      end
      if (cmd.pop) begin
         pops_in  = pops_ff + POP_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.load_last) begin
         hold_dl_in  = rda_dl_ff;
         hold_tag_in = rda_tag_ff;
         hole_in     = '0;
      end
      if (cmd.wr_op == WR_PARENT) begin
         hole_in = parent_idx;
      end
      if (cmd.wr_op == WR_CHILD) begin
         hole_in = pick_idx;
      end
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         now_ff       <= '0;
         pops_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         now_ff       <= now_in;
         pops_ff      <= pops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff     <= hole_in;
      hold_dl_ff  <= hold_dl_in;
      hold_tag_ff <= hold_tag_in;
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_tag_ff    <= (cmd.emit_status == ST_EXPIRED) ? rda_tag_ff : '0;
         rsp_secs_ff   <= (cmd.emit_status == ST_TICK && count_ff != '0) ?
                          rda_dl_ff - now_ff : '0;
         rsp_last_ff   <= (cmd.emit_status != ST_EXPIRED);
      end
   end

   always_comb begin
      sts           = '0;
      sts.full      = count_ff == CNT_W'(DEPTH);
      sts.hole_zero = hole_ff == '0;
      sts.add_less  = hold_dl_ff < rda_dl_ff;
      sts.pop_due   = (count_ff != '0) && (pops_ff < POP_W'(MAX_POPS)) &&
                      (rda_dl_ff <= now_ff);
      sts.more      = count_ff != CNT_W'(1);
      sts.has_left  = left_w < KID_W'(count_ff);
      sts.sd_move   = (hold_dl_ff > rda_dl_ff) || (right_ok && hold_dl_ff > rdb_dl_ff);
      sts.rsp_free  = !rsp_valid_ff || rsp_tready;
      sts.count     = count_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_tag    = rsp_tag_ff;
   assign rsp_secs   = rsp_secs_ff;
   assign rsp_last   = rsp_last_ff;
endmodule
